### rtl/nir_pkg.sv
// nir_pkg: types, nominal timings and the duration match function for the NEC IR frame decoder.
// No dependencies; imported by every module in rtl/.
package nir_pkg;

    typedef struct packed {
        logic [14:0] mark_duration;
        logic [14:0] space_duration;
        logic        end_of_frame;
    } t_symbol;

    typedef struct packed {
        logic        frame_ok;
        logic        repeat_hit;
        logic [15:0] address;
        logic [15:0] command;
        logic [3:0]  byte_total;
        logic [2:0]  byte_index;
        logic [7:0]  payload_byte;
        logic        last_result;
    } t_result;

    typedef struct packed {
        logic lead;
        logic rep_lead;
        logic one;
        logic zero;
    } t_sym_class;

    typedef struct packed {
        logic        frame_ok;
        logic        repeat_hit;
        logic [15:0] address;
        logic [15:0] command;
    } t_job;

    localparam logic [10:0] TOL_RESET      = 11'd200;

    localparam logic [13:0] NOM_LEAD_MARK  = 14'd9000;
    localparam logic [13:0] NOM_LEAD_SPACE = 14'd4500;
    localparam logic [13:0] NOM_REP_SPACE  = 14'd2250;
    localparam logic [13:0] NOM_BIT_MARK   = 14'd560;
    localparam logic [13:0] NOM_ONE_SPACE  = 14'd1690;
    localparam logic [13:0] NOM_ZERO_SPACE = 14'd560;

    localparam logic [7:0]  SYM_REPEAT     = 8'd2;
    localparam logic [7:0]  SYM_ADDR_LAST  = 8'd16;
    localparam logic [7:0]  SYM_MIN_FRAME  = 8'd17;
    localparam logic [7:0]  SYM_STANDARD   = 8'd34;
    localparam logic [7:0]  SYM_MAX        = 8'd255;

    // strict window: dur + tol > nom and dur < nom + tol
    function automatic logic near_nominal(input logic [14:0] dur, input logic [10:0] tol,
                                          input logic [13:0] nom);
        logic [15:0] lo_sum;
        logic [15:0] hi_sum;
        lo_sum = {1'b0, dur} + {5'b0, tol};
        hi_sum = {2'b0, nom} + {5'b0, tol};
        return (lo_sum > {2'b0, nom}) && ({1'b0, dur} < hi_sum);
    endfunction

endpackage

### rtl/nir_classify.sv
// nir_classify: sorts one mark/space pair into leader, repeat leader, one or zero.
// Depends on nir_pkg.
module nir_classify (
    input  nir_pkg::t_symbol    i_sym,
    input  logic [10:0]         i_tol,
    output nir_pkg::t_sym_class o_class
);
    import nir_pkg::*;

    logic m_lead;
    logic m_bit;
    logic s_lead;
    logic s_rep;
    logic s_one;
    logic s_zero;

    always_comb begin
        m_lead = near_nominal(i_sym.mark_duration, i_tol, NOM_LEAD_MARK);
        m_bit  = near_nominal(i_sym.mark_duration, i_tol, NOM_BIT_MARK);
        s_lead = near_nominal(i_sym.space_duration, i_tol, NOM_LEAD_SPACE);
        s_rep  = near_nominal(i_sym.space_duration, i_tol, NOM_REP_SPACE);
        s_one  = near_nominal(i_sym.space_duration, i_tol, NOM_ONE_SPACE);
        s_zero = near_nominal(i_sym.space_duration, i_tol, NOM_ZERO_SPACE);

        o_class.lead     = m_lead && s_lead;
        o_class.rep_lead = m_lead && s_rep;
        o_class.one      = m_bit && s_one;
        o_class.zero     = m_bit && s_zero && !s_one;
    end

endmodule

### rtl/nir_frame.sv
// nir_frame: per-symbol frame state, address/byte assembly and end-of-frame verdict.
// Depends on nir_pkg and nir_classify; writes payload bytes into the store in nir_emit.
module nir_frame #(
    parameter int MAX_PAYLOAD_BYTES = 8
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_sym_valid,
    input  nir_pkg::t_symbol                           i_sym,
    input  logic [10:0]                                i_tol,
    input  logic                                       i_job_ready,
    output logic                                       o_consume,
    output logic                                       o_job_valid,
    output nir_pkg::t_job                              o_job,
    output logic [$clog2(MAX_PAYLOAD_BYTES+2)-1:0]     o_job_len,
    output logic                                       o_job_bank,
    output logic                                       o_wr_en,
    output logic [((MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1):0] o_wr_addr,
    output logic [7:0]                                 o_wr_data
);
    import nir_pkg::*;

    localparam int IW = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1;
    localparam int CW = $clog2(MAX_PAYLOAD_BYTES + 2);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PAYLOAD_BYTES);

    t_sym_class cls;

    logic [7:0]    r_sym_cnt,   n_sym_cnt;
    logic          r_head_ok,   n_head_ok;
    logic          r_rep_ok,    n_rep_ok;
    logic [15:0]   r_addr,      n_addr;
    logic [7:0]    r_bs,        n_bs;
    logic [2:0]    r_bp,        n_bp;
    logic [CW-1:0] r_byte_cnt,  n_byte_cnt;
    logic          r_full_bad,  n_full_bad;
    logic          r_part_bad,  n_part_bad;
    logic [7:0]    r_byte0,     n_byte0;
    logic [7:0]    r_byte1,     n_byte1;
    logic          r_bank,      n_bank;
    logic [15:0]   r_rem_addr,  n_rem_addr;
    logic [15:0]   r_rem_cmd,   n_rem_cmd;

    logic          bad;
    logic          part_bad;
    logic [7:0]    shifted;
    logic          good;
    logic [15:0]   cmd;

    nir_classify u_classify (
        .i_sym   (i_sym),
        .i_tol   (i_tol),
        .o_class (cls)
    );

    assign o_consume = i_sym_valid && (!i_sym.end_of_frame || i_job_ready);

    always_comb begin
        n_sym_cnt  = r_sym_cnt;
        n_head_ok  = r_head_ok;
        n_rep_ok   = r_rep_ok;
        n_addr     = r_addr;
        n_bs       = r_bs;
        n_bp       = r_bp;
        n_byte_cnt = r_byte_cnt;
        n_full_bad = r_full_bad;
        n_part_bad = r_part_bad;
        n_byte0    = r_byte0;
        n_byte1    = r_byte1;
        n_bank     = r_bank;
        n_rem_addr = r_rem_addr;
        n_rem_cmd  = r_rem_cmd;

        bad      = !cls.one && !cls.zero;
        part_bad = r_part_bad || bad;
        shifted  = {cls.one, r_bs[7:1]};
        good     = 1'b0;
        cmd      = '0;

        o_wr_en     = 1'b0;
        o_wr_addr   = {r_bank, r_byte_cnt[IW-1:0]};
        o_wr_data   = shifted;
        o_job_valid = 1'b0;
        o_job       = '0;
        o_job_len   = '0;
        o_job_bank  = r_bank;

        if (o_consume) begin
            if (r_sym_cnt == '0) begin
                n_head_ok = cls.lead;
                n_rep_ok  = cls.rep_lead;
            end else if (r_sym_cnt <= SYM_ADDR_LAST) begin
                if (bad) begin
                    n_head_ok = 1'b0;
                end
                n_addr = {cls.one, r_addr[15:1]};
            end else begin
                n_bp = r_bp + 3'd1;
                if (n_bp == 3'd0) begin
                    if (r_byte_cnt < MAX_CNT) begin
                        o_wr_en = 1'b1;
                    end
                    if (r_byte_cnt == CW'(0)) begin
                        n_byte0 = shifted;
                    end
                    if (r_byte_cnt == CW'(1)) begin
                        n_byte1 = shifted;
                    end
                    n_full_bad = r_full_bad || part_bad;
                    n_part_bad = 1'b0;
                    if (r_byte_cnt <= MAX_CNT) begin
                        n_byte_cnt = r_byte_cnt + CW'(1);
                    end
                    n_bs = '0;
                end else begin
                    n_part_bad = part_bad;
                    n_bs       = shifted;
                end
            end
            if (r_sym_cnt != SYM_MAX) begin
                n_sym_cnt = r_sym_cnt + 8'd1;
            end

            if (i_sym.end_of_frame) begin
                o_job_valid = 1'b1;
                if (n_sym_cnt == SYM_REPEAT) begin
                    o_job.frame_ok   = n_rep_ok;
                    o_job.repeat_hit = n_rep_ok;
                    o_job.address    = n_rep_ok ? r_rem_addr : 16'd0;
                    o_job.command    = n_rep_ok ? r_rem_cmd : 16'd0;
                end else begin
                    good = (n_sym_cnt >= SYM_MIN_FRAME) && n_head_ok &&
                           (n_byte_cnt != '0) && (n_byte_cnt <= MAX_CNT) && !n_full_bad;
                    cmd  = (n_sym_cnt == SYM_STANDARD && n_byte_cnt == CW'(2)) ?
                           {n_byte1, n_byte0} : {8'd0, n_byte0};
                    if (good) begin
                        o_job.frame_ok = 1'b1;
                        o_job.address  = n_addr;
                        o_job.command  = cmd;
                        o_job_len      = n_byte_cnt;
                        n_rem_addr     = n_addr;
                        n_rem_cmd      = cmd;
                    end
                end
                n_bank     = !r_bank;
                n_sym_cnt  = '0;
                n_head_ok  = 1'b0;
                n_rep_ok   = 1'b0;
                n_addr     = '0;
                n_bs       = '0;
                n_bp       = '0;
                n_byte_cnt = '0;
                n_full_bad = 1'b0;
                n_part_bad = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym_cnt  <= '0;
            r_head_ok  <= 1'b0;
            r_rep_ok   <= 1'b0;
            r_addr     <= '0;
            r_bs       <= '0;
            r_bp       <= '0;
            r_byte_cnt <= '0;
            r_full_bad <= 1'b0;
            r_part_bad <= 1'b0;
            r_bank     <= 1'b0;
            r_rem_addr <= '0;
            r_rem_cmd  <= '0;
        end else begin
            r_sym_cnt  <= n_sym_cnt;
            r_head_ok  <= n_head_ok;
            r_rep_ok   <= n_rep_ok;
            r_addr     <= n_addr;
            r_bs       <= n_bs;
            r_bp       <= n_bp;
            r_byte_cnt <= n_byte_cnt;
            r_full_bad <= n_full_bad;
            r_part_bad <= n_part_bad;
            r_bank     <= n_bank;
            r_rem_addr <= n_rem_addr;
            r_rem_cmd  <= n_rem_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte0 <= n_byte0;
        r_byte1 <= n_byte1;
    end

    a_eof_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_valid |=> (r_sym_cnt == '0) && (r_byte_cnt == '0))
        else $error("frame state not cleared after end of frame");

    a_wr_payload_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (r_sym_cnt > SYM_ADDR_LAST) && (r_bp == 3'd7))
        else $error("payload write outside a completed byte");

    a_good_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_job_valid && o_job.frame_ok && !o_job.repeat_hit) |->
            (o_job_len != '0) && (o_job_len <= MAX_CNT))
        else $error("decoded frame with bad byte count");

endmodule

### rtl/nir_emit.sv
// nir_emit: two-bank payload store and result sequencer, one result per cycle while the output is not stalled.
// Depends on nir_pkg; fed by nir_frame.
module nir_emit #(
    parameter int MAX_PAYLOAD_BYTES = 8
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_job_valid,
    input  nir_pkg::t_job                              i_job,
    input  logic [$clog2(MAX_PAYLOAD_BYTES+2)-1:0]     i_job_len,
    input  logic                                       i_job_bank,
    output logic                                       o_job_ready,
    input  logic                                       i_wr_en,
    input  logic [((MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1):0] i_wr_addr,
    input  logic [7:0]                                 i_wr_data,
    output logic                                       o_valid,
    output nir_pkg::t_result                           o_result,
    input  logic                                       i_ready
);
    import nir_pkg::*;

    localparam int IW = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1;
    localparam int CW = $clog2(MAX_PAYLOAD_BYTES + 2);

    logic [7:0]    r_mem [2**(IW+1)];
    logic [7:0]    r_rd_data;

    logic          r_active;
    t_job          r_job;
    logic [CW-1:0] r_len;
    logic          r_bank;
    logic [CW-1:0] r_idx;

    logic          r_r_valid;
    t_result       r_r;
    logic          r_r_use;

    logic          r_out_valid;
    t_result       r_out;

    logic          out_free;
    logic          r_free;
    logic          issue;
    logic          last;

    assign out_free    = !r_out_valid || i_ready;
    assign r_free      = !r_r_valid || out_free;
    assign issue       = r_active && r_free;
    assign last        = (r_len == '0) || (r_idx + CW'(1) == r_len);
    assign o_job_ready = !r_active;
    assign o_valid     = r_out_valid;
    assign o_result    = r_out;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (issue) begin
            r_rd_data <= r_mem[{r_bank, r_idx[IW-1:0]}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_r_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_job_valid) begin
                r_active <= 1'b1;
            end else if (issue && last) begin
                r_active <= 1'b0;
            end
            if (issue) begin
                r_r_valid <= 1'b1;
            end else if (out_free) begin
                r_r_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_r_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job_valid) begin
            r_job  <= i_job;
            r_len  <= i_job_len;
            r_bank <= i_job_bank;
            r_idx  <= '0;
        end else if (issue) begin
            r_idx <= r_idx + CW'(1);
        end
        if (issue) begin
            r_r.frame_ok     <= r_job.frame_ok;
            r_r.repeat_hit   <= r_job.repeat_hit;
            r_r.address      <= r_job.address;
            r_r.command      <= r_job.command;
            r_r.byte_total   <= 4'(r_len);
            r_r.byte_index   <= 3'(r_idx);
            r_r.payload_byte <= '0;
            r_r.last_result  <= last;
            r_r_use          <= (r_len != '0);
        end
        if (out_free && r_r_valid) begin
            r_out.frame_ok     <= r_r.frame_ok;
            r_out.repeat_hit   <= r_r.repeat_hit;
            r_out.address      <= r_r.address;
            r_out.command      <= r_r.command;
            r_out.byte_total   <= r_r.byte_total;
            r_out.byte_index   <= r_r.byte_index;
            r_out.payload_byte <= r_r_use ? r_rd_data : 8'd0;
            r_out.last_result  <= r_r.last_result;
        end
    end

    a_job_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_valid |-> !r_active)
        else $error("job handed over while sequencer busy");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> ((r_len == '0) && (r_idx == '0)) || (r_idx < r_len))
        else $error("byte index beyond frame length");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.frame_ok) |->
            r_out.last_result && !r_out.repeat_hit && (r_out.address == 16'd0) &&
            (r_out.command == 16'd0) && (r_out.byte_total == 4'd0))
        else $error("failure result carries data");

endmodule

### rtl/nec_ir_frame_decoder_unit.sv
// nec_ir_frame_decoder_unit: NEC IR frame decoder top level.
// Depends on nir_pkg, nir_frame (with nir_classify) and nir_emit.
//
// Usage:
//  Input channel (i_valid/o_ready, i_symbol) takes one mark/space pair per request,
//  end_of_frame set on the last symbol of a frame. Output channel (o_valid/i_ready,
//  o_result) gives one result per payload byte of a decoded frame, or a single
//  repeat or failure result, last_result marking the final one.
//  i_cfg_we/i_cfg_wdata write the match tolerance; write only while idle.
//  Throughput: one symbol per cycle. An end-of-frame symbol waits in the input
//  register until the result sequencer has issued every result of the previous
//  frame; results leave at one per cycle while the receiver is ready, so every
//  payload byte of a frame holds the next end of frame back further.
//  After the end-of-frame request is accepted, the first result passes the input
//  register, the job hand-over, the store read and the output register.
//  Reset: tolerance returns to 200, frame state and remembered address/command
//  clear, both channels empty. No clearing pass.
//  Receiver stall: results wait in the output register; symbols keep flowing until
//  the next end of frame.
module nec_ir_frame_decoder_unit #(
    parameter int MAX_PAYLOAD_BYTES = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  nir_pkg::t_symbol i_symbol,
    output logic             o_valid,
    input  logic             i_ready,
    output nir_pkg::t_result o_result,
    input  logic             i_cfg_we,
    input  logic [10:0]      i_cfg_wdata
);
    import nir_pkg::*;

    localparam int IW = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1;
    localparam int CW = $clog2(MAX_PAYLOAD_BYTES + 2);

    logic          r_in_valid;
    t_symbol       r_in;
    logic [10:0]   r_tol;

    logic          consume;
    logic          job_ready;
    logic          job_valid;
    t_job          job;
    logic [CW-1:0] job_len;
    logic          job_bank;
    logic          wr_en;
    logic [IW:0]   wr_addr;
    logic [7:0]    wr_data;

    assign o_ready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_tol      <= TOL_RESET;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (i_cfg_we) begin
                r_tol <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in <= i_symbol;
        end
    end

    nir_frame #(
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sym_valid (r_in_valid),
        .i_sym       (r_in),
        .i_tol       (r_tol),
        .i_job_ready (job_ready),
        .o_consume   (consume),
        .o_job_valid (job_valid),
        .o_job       (job),
        .o_job_len   (job_len),
        .o_job_bank  (job_bank),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    nir_emit #(
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .i_job_len   (job_len),
        .i_job_bank  (job_bank),
        .o_job_ready (job_ready),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_ready     (i_ready)
    );

endmodule
